[hdl/sensor_frame_parser_with_checksum_assert.svh]
// ----------------------------------------------------------------------------
// sensor frame parser assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_PARSER_WITH_CHECKSUM_ASSERT_SVH
`define SENSOR_FRAME_PARSER_WITH_CHECKSUM_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clock, off during reset
`define SFP_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sfp assertion failed");
// next-cycle implication
`define SFP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sfp assertion failed");
`else
`define SFP_ASSERT_NOW(label, pre, post)
`define SFP_ASSERT_NEXT(label, pre, post)
`endif

`endif

[hdl/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types and constants of the sensor frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

   localparam logic [7:0] SYNC_A      = 8'hAA;
   localparam logic [7:0] SYNC_B      = 8'h55;
   localparam logic [7:0] REMAIN_FLAG = 8'h10;
   localparam logic [7:0] RES_MASK    = 8'h60;
   localparam logic [7:0] RES_9BIT    = 8'h00;
   localparam logic [7:0] RES_10BIT   = 8'h20;
   localparam logic [7:0] RES_11BIT   = 8'h40;
   localparam logic [15:0] FRAC_MASK  = 16'hFFF0;
   localparam logic [15:0] REMAIN_BASE = 16'd12;

   localparam int unsigned SKIP_BYTES  = 2;
   localparam int unsigned REC_BYTES   = 9;
   localparam int unsigned REC_EMIT    = 7;
   localparam int unsigned POS_W       = 4;

   // queue depth must be a power of two
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_SKIP  = 3'd1,
      PH_LIGHT = 3'd2,
      PH_CKSUM = 3'd3,
      PH_THERM = 3'd4
   } sfp_phase_type;

   typedef enum logic [1:0] {
      KIND_LIGHT   = 2'd0,
      KIND_VERDICT = 2'd1,
      KIND_TEMP    = 2'd2
   } sfp_kind_type;

   typedef enum logic {
      REG_SENSOR_FAMILY = 1'b0
   } sfp_reg_type;

   typedef struct packed {
      sfp_kind_type kind;
      logic [6:0]   channel;
      logic [15:0]  word_value;
      logic         checksum_ok;
      logic         frame_last;
      logic [7:0]   rec_lo;
      logic [7:0]   rec_hi;
      logic [7:0]   rec_cfg;
      logic [7:0]   rec_remain;
      logic         remain_valid;
   } sfp_item_type;

endpackage

[hdl/sfp_front.sv]
// ----------------------------------------------------------------------------
// sfp_front
// byte-level frame parser: sync hunt, light words, checksum, record capture
// ----------------------------------------------------------------------------
`include "sensor_frame_parser_with_checksum_assert.svh"

module sfp_front #(
   parameter int unsigned LIGHT_WORDS = 68,
   parameter int unsigned THERM_COUNT = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            byte_data,
   input  logic                  queue_full,
   output logic                  byte_ready,
   output logic                  push,
   output sfp_pkg::sfp_item_type push_item
);

   localparam logic [6:0] LAST_LIGHT = 7'(LIGHT_WORDS - 1);
   localparam logic [6:0] LAST_THERM = 7'(THERM_COUNT - 1);
   localparam logic [sfp_pkg::POS_W-1:0] POS_SKIP_LAST = sfp_pkg::POS_W'(sfp_pkg::SKIP_BYTES - 1);
   localparam logic [sfp_pkg::POS_W-1:0] POS_EMIT = sfp_pkg::POS_W'(sfp_pkg::REC_EMIT);
   localparam logic [sfp_pkg::POS_W-1:0] POS_END  = sfp_pkg::POS_W'(sfp_pkg::REC_BYTES - 1);

   sfp_pkg::sfp_phase_type phase_ff, phase_in;
   logic [1:0]                  sync_ff, sync_in;
   logic [sfp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [6:0]                  idx_ff, idx_in;
   logic [7:0]                  hold_ff, hold_in;
   logic [15:0]                 sum_ff, sum_in;
   logic [7:0]                  rec_lo_ff, rec_lo_in;
   logic [7:0]                  rec_hi_ff, rec_hi_in;
   logic [7:0]                  rec_cfg_ff, rec_cfg_in;
   logic [7:0]                  rec_rem_ff, rec_rem_in;
   logic                        accept;
   logic [15:0]                 word;
   logic [7:0]                  expect_byte;

   assign byte_ready  = !queue_full;
   assign accept      = byte_valid && byte_ready;
   assign word        = {hold_ff, byte_data};
   assign expect_byte = sync_ff[0] ? sfp_pkg::SYNC_B : sfp_pkg::SYNC_A;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfp_pkg::PH_HUNT;
         sync_ff  <= 2'd0;
         pos_ff   <= '0;
         idx_ff   <= 7'd0;
         hold_ff  <= 8'd0;
         sum_ff   <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         sync_ff  <= sync_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
         hold_ff  <= hold_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_lo_ff  <= rec_lo_in;
      rec_hi_ff  <= rec_hi_in;
      rec_cfg_ff <= rec_cfg_in;
      rec_rem_ff <= rec_rem_in;
   end

   always_comb begin
      phase_in   = phase_ff;
      sync_in    = sync_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      hold_in    = hold_ff;
      sum_in     = sum_ff;
      rec_lo_in  = rec_lo_ff;
      rec_hi_in  = rec_hi_ff;
      rec_cfg_in = rec_cfg_ff;
      rec_rem_in = rec_rem_ff;
      push       = 1'b0;
      push_item  = '{kind: sfp_pkg::KIND_LIGHT, channel: idx_ff, word_value: word,
                     checksum_ok: 1'b0, frame_last: 1'b0, rec_lo: rec_lo_ff,
                     rec_hi: rec_hi_ff, rec_cfg: rec_cfg_ff, rec_remain: rec_rem_ff,
                     remain_valid: (byte_data == sfp_pkg::REMAIN_FLAG)};
      if (accept) begin
         unique case (phase_ff)
            sfp_pkg::PH_SKIP: begin
               if (pos_ff == POS_SKIP_LAST) begin
                  phase_in = sfp_pkg::PH_LIGHT;
                  pos_in   = '0;
                  idx_in   = 7'd0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            sfp_pkg::PH_LIGHT: begin
               if (pos_ff == '0) begin
                  hold_in = byte_data;
                  pos_in  = sfp_pkg::POS_W'(1);
               end else begin
                  push   = 1'b1;
                  sum_in = sum_ff + word;
                  pos_in = '0;
                  if (idx_ff == LAST_LIGHT) begin
                     phase_in = sfp_pkg::PH_CKSUM;
                     idx_in   = 7'd0;
                  end else begin
                     idx_in = idx_ff + 7'd1;
                  end
               end
            end
            sfp_pkg::PH_CKSUM: begin
               if (pos_ff == '0) begin
                  hold_in = byte_data;
                  pos_in  = sfp_pkg::POS_W'(1);
               end else begin
                  push                  = 1'b1;
                  push_item.kind        = sfp_pkg::KIND_VERDICT;
                  push_item.channel     = 7'd0;
                  push_item.checksum_ok = (word == sum_ff);
                  push_item.frame_last  = (word != sum_ff);
                  pos_in                = '0;
                  idx_in                = 7'd0;
                  sync_in               = 2'd0;
                  phase_in = (word == sum_ff) ? sfp_pkg::PH_THERM : sfp_pkg::PH_HUNT;
               end
            end
            sfp_pkg::PH_THERM: begin
               unique case (pos_ff)
                  sfp_pkg::POS_W'(0): rec_lo_in  = byte_data;
                  sfp_pkg::POS_W'(1): rec_hi_in  = byte_data;
                  sfp_pkg::POS_W'(4): rec_cfg_in = byte_data;
                  sfp_pkg::POS_W'(6): rec_rem_in = byte_data;
                  default: ;
               endcase
               if (pos_ff == POS_EMIT) begin
                  push                 = 1'b1;
                  push_item.kind       = sfp_pkg::KIND_TEMP;
                  push_item.word_value = 16'd0;
                  push_item.frame_last = (idx_ff == LAST_THERM);
               end
               if (pos_ff == POS_END) begin
                  pos_in = '0;
                  if (idx_ff == LAST_THERM) begin
                     phase_in = sfp_pkg::PH_HUNT;
                     sync_in  = 2'd0;
                     idx_in   = 7'd0;
                  end else begin
                     idx_in = idx_ff + 7'd1;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            default: begin
               phase_in = sfp_pkg::PH_HUNT;
               if (byte_data == expect_byte) begin
                  if (sync_ff == 2'd3) begin
                     phase_in = sfp_pkg::PH_SKIP;
                     sync_in  = 2'd0;
                     pos_in   = '0;
                     idx_in   = 7'd0;
                     sum_in   = 16'd0;
                  end else begin
                     sync_in = sync_ff + 2'd1;
                  end
               end else begin
                  sync_in = (byte_data == sfp_pkg::SYNC_A) ? 2'd1 : 2'd0;
               end
            end
         endcase
      end
   end

   `SFP_ASSERT_NOW(a_front_push_needs_room, push, !queue_full)
   `SFP_ASSERT_NOW(a_front_fail_ends_frame,
      push && (push_item.kind == sfp_pkg::KIND_VERDICT) && !push_item.checksum_ok,
      push_item.frame_last)

endmodule

[hdl/sfp_queue.sv]
// ----------------------------------------------------------------------------
// sfp_queue
// short item queue between the parser and the decode stage
// ----------------------------------------------------------------------------
`include "sensor_frame_parser_with_checksum_assert.svh"

module sfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  sfp_pkg::sfp_item_type wr_item,
   output sfp_pkg::sfp_item_type rd_item,
   input  logic                  push,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty
);

   sfp_pkg::sfp_item_type        mem_ff [sfp_pkg::QUEUE_DEPTH];
   logic [sfp_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sfp_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sfp_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign do_push = push;
   assign do_pop  = pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_comb begin
      wr_ptr_in = do_push ? sfp_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? sfp_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign rd_item = mem_ff[rd_ptr_ff];

   assign full      = (count_ff == sfp_pkg::QCNT_W'(sfp_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);

   `SFP_ASSERT_NOW(a_queue_count_bound, 1'b1,
      count_ff <= sfp_pkg::QCNT_W'(sfp_pkg::QUEUE_DEPTH))
   `SFP_ASSERT_NOW(a_queue_pop_nonempty, do_pop, count_ff != '0)

endmodule

[hdl/sfp_back.sv]
// ----------------------------------------------------------------------------
// sfp_back
// temperature decode and result output register
// ----------------------------------------------------------------------------
`include "sensor_frame_parser_with_checksum_assert.svh"

module sfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sensor_family,
   input  logic                  item_valid,
   input  sfp_pkg::sfp_item_type item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [6:0]            rsp_channel,
   output logic [15:0]           rsp_word_value,
   output logic signed [15:0]    rsp_temperature,
   output logic                  rsp_checksum_ok,
   output logic                  rsp_frame_last
);

   logic               valid_ff, valid_in;
   logic [1:0]         kind_ff;
   logic [6:0]         channel_ff;
   logic [15:0]        word_ff;
   logic signed [15:0] temp_ff;
   logic               ok_ff;
   logic               last_ff;
   logic [15:0]        raw;
   logic [15:0]        shifted;
   logic [15:0]        temp_in;
   logic [7:0]         res_cfg;

   assign item_pop = item_valid && (!valid_ff || rsp_ready);
   assign raw      = {item.rec_hi, item.rec_lo};
   assign shifted  = {raw[12:0], 3'b000};
   assign res_cfg  = item.rec_cfg & sfp_pkg::RES_MASK;

   always_comb begin
      temp_in = 16'd0;
      if (item.kind == sfp_pkg::KIND_TEMP) begin
         if (sensor_family) begin
            temp_in = shifted;
            if (item.remain_valid) begin
               temp_in = (shifted & sfp_pkg::FRAC_MASK) + sfp_pkg::REMAIN_BASE
                         - {8'd0, item.rec_remain};
            end
         end else begin
            unique case (res_cfg)
               sfp_pkg::RES_9BIT:  temp_in = raw & 16'hFFF8;
               sfp_pkg::RES_10BIT: temp_in = raw & 16'hFFFC;
               sfp_pkg::RES_11BIT: temp_in = raw & 16'hFFFE;
               default:            temp_in = raw;
            endcase
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (item_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         kind_ff    <= item.kind;
         channel_ff <= item.channel;
         word_ff    <= item.word_value;
         temp_ff    <= temp_in;
         ok_ff      <= item.checksum_ok;
         last_ff    <= item.frame_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_channel     = channel_ff;
   assign rsp_word_value  = word_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_checksum_ok = ok_ff;
   assign rsp_frame_last  = last_ff;

   `SFP_ASSERT_NEXT(a_back_pop_loads, item_pop, valid_ff)

endmodule

[hdl/sensor_frame_parser_with_checksum.sv]
// ----------------------------------------------------------------------------
// sensor_frame_parser_with_checksum
// sync-word frame parser with 16-bit sum checksum and thermometer decoding
// ----------------------------------------------------------------------------
//  channel   direction  ports                     carries
//  req       in         req_valid/req_ready       one received byte per item
//  rsp       out        rsp_valid/rsp_ready       light word, verdict or temperature
//  csr       in/out     csr_psel..csr_pready      sensor_family at byte address 0
//
//  one byte accepted per cycle while req_ready is high; each result is registered
//  in the item queue, then in the output register; reset needs no clearing pass
//  req_ready drops only when the two-entry item queue is full, which happens
//  when rsp is held off; while it is full every byte waits, result or not
// ----------------------------------------------------------------------------
module sensor_frame_parser_with_checksum #(
   parameter int unsigned LIGHT_WORDS = 68,
   parameter int unsigned THERM_COUNT = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [6:0]                         rsp_channel,
   output logic [15:0]                        rsp_word_value,
   output logic signed [15:0]                 rsp_temperature,
   output logic                               rsp_checksum_ok,
   output logic                               rsp_frame_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sfp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sfp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sfp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic                  family_ff, family_in;
   logic                  csr_hit;
   sfp_pkg::sfp_item_type push_item;
   sfp_pkg::sfp_item_type head_item;
   logic                  q_full;
   logic                  q_not_empty;
   logic                  push;
   logic                  pop;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == sfp_pkg::REG_SENSOR_FAMILY);

   always_comb begin
      family_in = family_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         family_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff <= 1'b1;
      end else begin
         family_ff <= family_in;
      end
   end

   assign csr_prdata = csr_hit ? {{(sfp_pkg::CSR_DATA_W-1){1'b0}}, family_ff} : '0;

   sfp_front #(
      .LIGHT_WORDS (LIGHT_WORDS),
      .THERM_COUNT (THERM_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_data  (req_rx_byte),
      .queue_full (q_full),
      .byte_ready (req_ready),
      .push       (push),
      .push_item  (push_item)
   );

   sfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_item   (push_item),
      .rd_item   (head_item),
      .push      (push),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   sfp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .sensor_family   (family_ff),
      .item_valid      (q_not_empty),
      .item            (head_item),
      .item_pop        (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_channel     (rsp_channel),
      .rsp_word_value  (rsp_word_value),
      .rsp_temperature (rsp_temperature),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule
